[src/ubpl_pkg.sv]
// ----------------------------------------------------------------------------
// ubpl_pkg
// Shared types and constants for the byte pattern locator: beat payloads,
// configuration register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package ubpl_pkg;

	localparam int MAX_PATTERN_BYTES = 32;
	localparam int PATTERN_BITS      = MAX_PATTERN_BYTES * 8;
	localparam int CFG_REG_BITS      = 64;
	localparam int CFG_PATTERN_REGS  = PATTERN_BITS / CFG_REG_BITS;
	localparam int LEN_W             = 6;
	localparam int WIN_IDX_W         = 5;
	localparam int POS_W             = 32;
	localparam int CFG_INDEX_W       = 3;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_PATTERN_LO     = 3'd0;
	localparam cfg_index_t REG_PATTERN_MID_LO = 3'd1;
	localparam cfg_index_t REG_PATTERN_MID_HI = 3'd2;
	localparam cfg_index_t REG_PATTERN_HI     = 3'd3;
	localparam cfg_index_t REG_PATTERN_LENGTH = 3'd4;

	localparam logic [LEN_W-1:0] LENGTH_RESET = 6'd1;
	localparam logic [LEN_W-1:0] LENGTH_MAX   = 6'd32;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} byte_item_t;

	typedef struct packed {
		logic             pattern_found;
		logic [POS_W-1:0] first_position;
		logic             more_than_one;
	} result_item_t;

	typedef struct packed {
		logic [PATTERN_BITS-1:0] pattern;
		logic [LEN_W-1:0]        pattern_length;
	} ubpl_cfg_t;

endpackage

[src/ubpl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ubpl_cfg_regs
// Configuration register file: four 64-bit pattern words and the pattern
// length. Writes to indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
module ubpl_cfg_regs
	import ubpl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  cfg_index_t              wr_index,
	input  logic [CFG_REG_BITS-1:0] wr_data,
	output ubpl_cfg_t               cfg
);

	logic [CFG_REG_BITS-1:0] pattern_q [CFG_PATTERN_REGS];
	logic [LEN_W-1:0]        length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_PATTERN_REGS; i++) begin
				pattern_q[i] <= '0;
			end
			length_q <= LENGTH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PATTERN_LO:     pattern_q[0] <= wr_data;
				REG_PATTERN_MID_LO: pattern_q[1] <= wr_data;
				REG_PATTERN_MID_HI: pattern_q[2] <= wr_data;
				REG_PATTERN_HI:     pattern_q[3] <= wr_data;
				REG_PATTERN_LENGTH: length_q <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < CFG_PATTERN_REGS; i++) begin
			cfg.pattern[i*CFG_REG_BITS +: CFG_REG_BITS] = pattern_q[i];
		end
		cfg.pattern_length = length_q;
	end

endmodule

[src/ubpl_match_stage.sv]
// ----------------------------------------------------------------------------
// ubpl_match_stage
// Byte window, parallel pattern compare and per-stream match bookkeeping.
// Each step shifts one byte in, checks the newest bytes against the pattern
// and, on the last byte of a stream, presents the result and clears.
// ----------------------------------------------------------------------------
module ubpl_match_stage
	import ubpl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  byte_item_t   item,
	input  ubpl_cfg_t    cfg,
	output result_item_t result
);

	logic [7:0]           win_q [MAX_PATTERN_BYTES];
	logic [7:0]           win_next [MAX_PATTERN_BYTES];
	logic [POS_W-1:0]     seen_q;
	logic [POS_W-1:0]     first_q;
	logic                 match_q;
	logic                 more_q;

	logic [LEN_W-1:0]     len_c;
	logic [WIN_IDX_W-1:0] len_m1;
	logic                 bytes_ok;
	logic                 hit;
	logic [POS_W-1:0]     start_pos;
	logic                 match_n;
	logic [POS_W-1:0]     first_n;
	logic                 more_n;
	logic [POS_W-1:0]     seen_n;

	always_comb begin
		win_next[0] = item.data_byte;
		for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	// The window holds the newest byte at entry 0, so pattern byte k lines up
	// with entry len-1-k.
	always_comb begin
		logic [WIN_IDX_W-1:0] idx;
		len_c    = (cfg.pattern_length > LENGTH_MAX) ? LENGTH_MAX : cfg.pattern_length;
		len_m1   = WIN_IDX_W'(len_c - 6'd1);
		bytes_ok = 1'b1;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			idx = len_m1 - WIN_IDX_W'(k);
			if (LEN_W'(k) < len_c) begin
				if (win_next[idx] != cfg.pattern[8*k +: 8]) begin
					bytes_ok = 1'b0;
				end
			end
		end
		hit       = (len_c != '0) && (seen_q >= POS_W'(len_m1)) && bytes_ok;
		start_pos = seen_q - POS_W'(len_m1);
	end

	always_comb begin
		match_n = match_q | hit;
		first_n = (hit && !match_q) ? start_pos : first_q;
		more_n  = more_q | (hit && match_q);
		seen_n  = (seen_q == '1) ? seen_q : seen_q + POS_W'(1);

		result.pattern_found  = match_n;
		result.first_position = match_n ? first_n : '0;
		result.more_than_one  = more_n;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			first_q <= '0;
			match_q <= 1'b0;
			more_q  <= 1'b0;
		end else if (step) begin
			if (item.end_of_stream) begin
				seen_q  <= '0;
				first_q <= '0;
				match_q <= 1'b0;
				more_q  <= 1'b0;
			end else begin
				seen_q  <= seen_n;
				first_q <= first_n;
				match_q <= match_n;
				more_q  <= more_n;
			end
		end
	end

endmodule

[src/unique_byte_pattern_locator_core.sv]
// ----------------------------------------------------------------------------
// unique_byte_pattern_locator_core
// Path: a last byte passes the input register, its result the result register.
// Throughput: one byte per cycle, set by the combinational window compare,
// except while a last byte waits for a stalled result to leave.
// Reset: arst_n clears the pattern to zero, the length to one and the stream
// state but the window; the block takes beats again right after release.
// ----------------------------------------------------------------------------
module unique_byte_pattern_locator_core
	import ubpl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  byte_item_t              byte_item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output result_item_t            result_item,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  cfg_index_t              cfg_index,
	input  logic [CFG_REG_BITS-1:0] cfg_data
);

	ubpl_cfg_t    cfg;
	logic         valid_s1;
	byte_item_t   item_s1;
	logic         advance;
	logic         accept;
	result_item_t result_c;
	logic         result_valid_q;
	result_item_t result_q;

	assign cfg_ready = 1'b1;

	ubpl_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Only a last byte needs room in the result register; other bytes keep
	// flowing while a result waits.
	assign advance    = valid_s1 &&
		!(item_s1.end_of_stream && result_valid_q && result_stall);
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
	end

	ubpl_match_stage u_match_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.end_of_stream) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_stream) begin
			result_q <= result_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule
